// ===== rtl/sgns_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgns_pkg: shared types and constants for the skip-gram update block
// Table geometry, fixed-point widths, opcodes, controller states, the
// controller/datapath command and status words and the sigmoid lookup table.
// ----------------------------------------------------------------------------
package sgns_pkg;

	localparam int NUM_WORDS   = 4096;
	localparam int DIM         = 50;
	localparam int ROW_W       = $clog2(NUM_WORDS);
	localparam int TABLE_WORDS = NUM_WORDS * DIM;
	localparam int ADDR_W      = $clog2(TABLE_WORDS);
	localparam int EL_W        = (DIM > 1) ? $clog2(DIM) : 1;

	localparam int WORD_IN_W = 12;
	localparam int ELEM_IN_W = 6;
	localparam int W_W       = 32;
	localparam int LR_W      = 24;
	localparam int PROB_W    = 17;
	localparam int ERR_W     = 18;
	localparam int G_W       = 26;
	localparam int TERM_W    = 40;
	localparam int ACC_W     = TERM_W + $clog2(DIM) + 1;
	localparam int DELTA_W   = 34;

	localparam logic [LR_W-1:0] LR_RESET = 24'd83886;

	localparam int SIG_ENTRIES = 1024;
	localparam int SIG_IX_W    = $clog2(SIG_ENTRIES);

	typedef enum logic [1:0] {
		OP_TRAIN  = 2'd0,
		OP_WR_IN  = 2'd1,
		OP_WR_OUT = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_DOT_WAIT,
		ST_SCORE,
		ST_SIG,
		ST_GAIN,
		ST_UPD,
		ST_UPD_WAIT,
		ST_WRITE,
		ST_READ,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic            load;
		logic            rd_en;
		logic            dot;
		logic            upd;
		logic            use_item_el;
		logic [EL_W-1:0] elem;
		logic            score_en;
		logic            sig_en;
		logic            gain_en;
		logic            wr_en;
		logic            result_en;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} stat_t;

	typedef logic [PROB_W-1:0] sig_rom_t [SIG_ENTRIES];

	// restoring long division, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, dv}) begin
				r    = r - {1'b0, dv};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid((i-512)/64) in Q0.16, built from successive powers of e^(-1/64)
	function automatic sig_rom_t build_sig_rom();
		sig_rom_t                 rom;
		logic [63:0]              t;
		logic [63:0]              d;
		logic [63:0]              q;
		for (int i = 0; i < SIG_ENTRIES; i++) begin
			rom[i] = '0;
		end
		t = 64'd1 << 32;
		for (int k = 0; k <= 512; k++) begin
			d = (64'd1 << 32) + t;
			if (k < 512) begin
				q = udiv64((64'd1 << 48) + (d >> 1), d);
				rom[512 + k] = q[PROB_W-1:0];
			end
			if (k > 0) begin
				q = udiv64((t << 16) + (d >> 1), d);
				rom[512 - k] = q[PROB_W-1:0];
			end
			t = (t * 64'd4228380000 + (64'd1 << 31)) >> 32;
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage
`default_nettype wire

// ===== rtl/sgns_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgns_ram: simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module sgns_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sgns_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgns_ctrl: sequencer for the skip-gram update block
// Walks one item through dot pass, sigmoid, gain, update pass and result,
// or through a single table access, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module sgns_ctrl
	import sgns_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [1:0] opcode,
	input  wire stat_t      stat,
	output      cmd_t       cmd
);

	state_t          state_q;
	state_t          state_nxt;
	logic [EL_W-1:0] elem_q;
	logic            last_el;

	assign last_el = (elem_q == EL_W'(DIM - 1));

	// state register and element counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elem_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_DOT) || (state_q == ST_UPD)) begin
				elem_q <= last_el ? '0 : elem_q + 1'b1;
			end else begin
				elem_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(opcode))
						OP_TRAIN:  state_nxt = ST_DOT;
						OP_WR_IN:  state_nxt = ST_WRITE;
						OP_WR_OUT: state_nxt = ST_WRITE;
						OP_READ:   state_nxt = ST_READ;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_DOT:      if (last_el) state_nxt = ST_DOT_WAIT;
			ST_DOT_WAIT: if (!stat.busy) state_nxt = ST_SCORE;
			ST_SCORE:    state_nxt = ST_SIG;
			ST_SIG:      state_nxt = ST_GAIN;
			ST_GAIN:     state_nxt = ST_UPD;
			ST_UPD:      if (last_el) state_nxt = ST_UPD_WAIT;
			ST_UPD_WAIT: if (!stat.busy) state_nxt = ST_RESULT;
			ST_WRITE:    state_nxt = ST_RESULT;
			ST_READ:     state_nxt = ST_RESULT;
			ST_RESULT:   if (stat.out_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		cmd.elem = elem_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DOT: begin
				cmd.rd_en = 1'b1;
				cmd.dot   = 1'b1;
			end
			ST_SCORE: cmd.score_en = 1'b1;
			ST_SIG:   cmd.sig_en = 1'b1;
			ST_GAIN:  cmd.gain_en = 1'b1;
			ST_UPD: begin
				cmd.rd_en = 1'b1;
				cmd.upd   = 1'b1;
			end
			ST_WRITE: begin
				cmd.wr_en       = 1'b1;
				cmd.use_item_el = 1'b1;
			end
			ST_READ: begin
				cmd.rd_en       = 1'b1;
				cmd.use_item_el = 1'b1;
			end
			ST_RESULT: cmd.result_en = stat.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/sgns_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgns_dp: datapath for the skip-gram update block
// Embedding RAMs, two-stage multiply/accumulate pipe, sigmoid lookup,
// gain, saturating write-back and the output register.
// ----------------------------------------------------------------------------
module sgns_dp
	import sgns_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output      stat_t                stat,
	input  wire logic                 cfg_wr_en,
	input  wire logic [LR_W-1:0]      cfg_wr_data,
	input  wire logic [1:0]           opcode,
	input  wire logic [WORD_IN_W-1:0] center_word,
	input  wire logic [WORD_IN_W-1:0] context_word,
	input  wire logic                 label,
	input  wire logic [ELEM_IN_W-1:0] element_index,
	input  wire logic signed [W_W-1:0] weight_value,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic signed [W_W-1:0] score,
	output      logic [PROB_W-1:0]    probability,
	output      logic signed [W_W-1:0] in_weight,
	output      logic signed [W_W-1:0] out_weight
);

	function automatic logic signed [W_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'($signed(32'sh7fffffff));
		lo = ACC_W'($signed(32'sh80000000));
		if (a > hi) return 32'sh7fffffff;
		if (a < lo) return 32'sh80000000;
		return a[W_W-1:0];
	endfunction

	function automatic logic signed [W_W-1:0] sat_upd(input logic signed [DELTA_W:0] a);
		logic signed [DELTA_W:0] hi;
		logic signed [DELTA_W:0] lo;
		hi = (DELTA_W+1)'($signed(32'sh7fffffff));
		lo = (DELTA_W+1)'($signed(32'sh80000000));
		if (a > hi) return 32'sh7fffffff;
		if (a < lo) return 32'sh80000000;
		return a[W_W-1:0];
	endfunction

	// item and configuration registers
	op_t                     op_q;
	logic                    label_q;
	logic [ELEM_IN_W-1:0]    el_q;
	logic signed [W_W-1:0]   wv_q;
	logic [ADDR_W-1:0]       ubase_q;
	logic [ADDR_W-1:0]       vbase_q;
	logic [LR_W-1:0]         lr_q;
	logic                    el_ok;

	// arithmetic state
	logic signed [ACC_W-1:0] acc_q;
	logic signed [W_W-1:0]   score_q;
	logic [PROB_W-1:0]       prob_q;
	logic signed [G_W-1:0]   g_q;

	// pipe
	logic                    vld_s1, upd_s1;
	logic [ADDR_W-1:0]       ua_s1, va_s1;
	logic                    vld_s2, upd_s2;
	logic [ADDR_W-1:0]       ua_s2, va_s2;
	logic signed [W_W-1:0]   uo_s2, vo_s2;
	logic signed [63:0]      ma_s2;
	logic signed [57:0]      mb_s2;

	// output register
	logic                    out_valid_q;
	logic signed [W_W-1:0]   score_o_q, in_w_o_q, out_w_o_q;
	logic [PROB_W-1:0]       prob_o_q;

	// comb
	logic [ADDR_W-1:0]       off;
	logic [ADDR_W-1:0]       u_addr, v_addr;
	logic signed [W_W-1:0]   u_rd, v_rd;
	logic signed [W_W-1:0]   ma_a;
	logic signed [63:0]      ma;
	logic signed [57:0]      mb;
	logic signed [TERM_W-1:0] term;
	logic signed [W_W-1:0]   new_u, new_v;
	logic                    u_we, v_we;
	logic [ADDR_W-1:0]       u_wa, v_wa;
	logic signed [W_W-1:0]   u_wd, v_wd;
	logic signed [14:0]      sig_ix;
	logic [SIG_IX_W-1:0]     sig_ix_c;
	logic signed [ERR_W-1:0] err;
	logic signed [42:0]      lr_err;

	assign el_ok  = (32'(el_q) < 32'(DIM));
	assign off    = cmd.use_item_el ? ADDR_W'(el_q) : ADDR_W'(cmd.elem);
	assign u_addr = ubase_q + off;
	assign v_addr = vbase_q + off;

	// capture item fields and learning rate
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(opcode);
			label_q <= label;
			el_q    <= element_index;
			wv_q    <= weight_value;
			ubase_q <= ADDR_W'(center_word[ROW_W-1:0]) * ADDR_W'(DIM);
			vbase_q <= ADDR_W'(context_word[ROW_W-1:0]) * ADDR_W'(DIM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
		end else if (cfg_wr_en) begin
			lr_q <= cfg_wr_data;
		end
	end

	// table writes: update pass write-back or a single load
	always_comb begin
		u_we = 1'b0;
		v_we = 1'b0;
		u_wa = u_addr;
		v_wa = v_addr;
		u_wd = wv_q;
		v_wd = wv_q;
		if (vld_s2 && upd_s2) begin
			u_we = 1'b1;
			v_we = 1'b1;
			u_wa = ua_s2;
			v_wa = va_s2;
			u_wd = new_u;
			v_wd = new_v;
		end else if (cmd.wr_en && el_ok) begin
			u_we = (op_q == OP_WR_IN);
			v_we = (op_q == OP_WR_OUT);
		end
	end

	sgns_ram #(.DEPTH(TABLE_WORDS), .WIDTH(W_W), .AW(ADDR_W)) u_in_tab (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_wa),
		.wdata (u_wd),
		.re    (cmd.rd_en),
		.raddr (u_addr),
		.rdata (u_rd)
	);

	sgns_ram #(.DEPTH(TABLE_WORDS), .WIDTH(W_W), .AW(ADDR_W)) u_out_tab (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_wa),
		.wdata (v_wd),
		.re    (cmd.rd_en),
		.raddr (v_addr),
		.rdata (v_rd)
	);

	// stage 1 multipliers: u*v on the dot pass, g*v and g*u on the update pass
	assign ma_a = upd_s1 ? W_W'(g_q) : u_rd;
	assign ma   = $signed(ma_a) * $signed(v_rd);
	assign mb   = $signed(g_q) * $signed(u_rd);

	// pipe valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.dot | cmd.upd;
			vld_s2 <= vld_s1;
		end
	end

	// pipe payload
	always_ff @(posedge clk) begin
		upd_s1 <= cmd.upd;
		ua_s1  <= u_addr;
		va_s1  <= v_addr;
		upd_s2 <= upd_s1;
		ua_s2  <= ua_s1;
		va_s2  <= va_s1;
		uo_s2  <= u_rd;
		vo_s2  <= v_rd;
		ma_s2  <= ma;
		mb_s2  <= mb;
	end

	// stage 2: accumulate or saturate and write back
	assign term  = ma_s2[63:24];
	assign new_u = sat_upd((DELTA_W+1)'(uo_s2) + (DELTA_W+1)'($signed(ma_s2[57:24])));
	assign new_v = sat_upd((DELTA_W+1)'(vo_s2) + (DELTA_W+1)'($signed(mb_s2[57:24])));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (vld_s2 && !upd_s2) begin
			acc_q <= acc_q + ACC_W'(term);
		end
	end

	// score, sigmoid lookup and gain
	assign sig_ix   = 15'($signed(score_q[31:18])) + 15'sd512;
	assign sig_ix_c = (sig_ix < 15'sd0) ? '0 :
		(sig_ix > 15'(SIG_ENTRIES - 1)) ? SIG_IX_W'(SIG_ENTRIES - 1) : sig_ix[SIG_IX_W-1:0];
	assign err      = (label_q ? 18'sd65536 : 18'sd0) - $signed(ERR_W'(prob_q));
	assign lr_err   = $signed({1'b0, lr_q}) * err;

	always_ff @(posedge clk) begin
		if (cmd.score_en) begin
			score_q <= sat_acc(acc_q);
		end
		if (cmd.sig_en) begin
			prob_q <= SIG_ROM[sig_ix_c];
		end
		if (cmd.gain_en) begin
			g_q <= lr_err[41:16];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_en) begin
			score_o_q <= '0;
			prob_o_q  <= '0;
			in_w_o_q  <= '0;
			out_w_o_q <= '0;
			if (op_q == OP_TRAIN) begin
				score_o_q <= score_q;
				prob_o_q  <= prob_q;
			end else if ((op_q == OP_READ) && el_ok) begin
				in_w_o_q  <= u_rd;
				out_w_o_q <= v_rd;
			end
		end
	end

	assign stat.busy     = vld_s1 | vld_s2;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign score         = score_o_q;
	assign probability   = prob_o_q;
	assign in_weight     = in_w_o_q;
	assign out_weight    = out_w_o_q;

endmodule
`default_nettype wire

// ===== rtl/skipgram_negative_sampling_update_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skipgram_negative_sampling_update_top: skip-gram SGD step engine
// Holds the input and output embedding tables and trains one
// (center, context, label) pair per train word.
//
// Input channel in_valid/in_ready takes one word: a train pair, a weight
// load into either table or a weight read. Output channel out_valid/
// out_ready returns exactly one word per input word. cfg_wr_en/cfg_wr_data
// set the Q0.24 learning rate at once.
// A train word runs one dot pass and one update pass, each one element a
// cycle through the table RAM ports, plus pipe drain, score, sigmoid and
// gain steps. A load or read makes a single table access. One word is
// worked on at a time; in_ready is high while the sequencer is idle.
// The result sits in an output register, so the next word is accepted while
// it waits; if the receiver stalls, a second result holds the sequencer
// until the register frees. Reset clears control and sets the learning rate
// to 0.005; table contents are undefined until written.
// ----------------------------------------------------------------------------
module skipgram_negative_sampling_update_top
	import sgns_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic [1:0]            opcode,
	input  wire logic [WORD_IN_W-1:0]  center_word,
	input  wire logic [WORD_IN_W-1:0]  context_word,
	input  wire logic                  label,
	input  wire logic [ELEM_IN_W-1:0]  element_index,
	input  wire logic signed [W_W-1:0] weight_value,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic signed [W_W-1:0] score,
	output      logic [PROB_W-1:0]     probability,
	output      logic signed [W_W-1:0] in_weight,
	output      logic signed [W_W-1:0] out_weight,
	input  wire logic                  cfg_wr_en,
	input  wire logic [LR_W-1:0]       cfg_wr_data
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	sgns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.stat     (stat),
		.cmd      (cmd)
	);

	// tables and arithmetic
	sgns_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.opcode        (opcode),
		.center_word   (center_word),
		.context_word  (context_word),
		.label         (label),
		.element_index (element_index),
		.weight_value  (weight_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.score         (score),
		.probability   (probability),
		.in_weight     (in_weight),
		.out_weight    (out_weight)
	);

endmodule
`default_nettype wire

// ===== sim/skipgram_negative_sampling_update_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skipgram_negative_sampling_update_top_tb: self-checking bench for the
// skip-gram SGD step engine
// Loads embedding rows, trains pairs and reads weights back through the
// valid/ready channels. A local copy of both tables and the learning rate
// predicts every result word, which is checked field by field in order.
// ----------------------------------------------------------------------------
module skipgram_negative_sampling_update_top_tb;
	import sgns_pkg::*;

	localparam int NROWS = 4;

	typedef struct packed {
		logic [1:0]            op;
		logic [WORD_IN_W-1:0]  cw;
		logic [WORD_IN_W-1:0]  xw;
		logic                  lab;
		logic [ELEM_IN_W-1:0]  el;
		logic signed [W_W-1:0] wv;
	} item_t;

	typedef struct packed {
		logic signed [W_W-1:0] sc;
		logic [PROB_W-1:0]     pr;
		logic signed [W_W-1:0] iw;
		logic signed [W_W-1:0] ow;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = '0;
	logic [WORD_IN_W-1:0] center_word = '0;
	logic [WORD_IN_W-1:0] context_word = '0;
	logic label = 1'b0;
	logic [ELEM_IN_W-1:0] element_index = '0;
	logic signed [W_W-1:0] weight_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [W_W-1:0] score;
	logic [PROB_W-1:0] probability;
	logic signed [W_W-1:0] in_weight;
	logic signed [W_W-1:0] out_weight;
	logic cfg_wr_en = 1'b0;
	logic [LR_W-1:0] cfg_wr_data = '0;

	skipgram_negative_sampling_update_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .center_word(center_word), .context_word(context_word),
		.label(label), .element_index(element_index), .weight_value(weight_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.score(score), .probability(probability),
		.in_weight(in_weight), .out_weight(out_weight),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// predictor state: touched rows only, keyed by row*DIM+el
	logic signed [W_W-1:0] in_tab [int];
	logic signed [W_W-1:0] out_tab [int];
	logic [LR_W-1:0] lr_model;
	logic [PROB_W-1:0] sig_lut [SIG_ENTRIES];

	item_t pending_words [$];
	res_t  expected_results [$];
	int n_mismatch = 0;
	int n_checked = 0;
	int n_train = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int phase_no = -1;
	int hold_off = 0;
	bit long_done = 1'b0;
	bit in_fire_q = 1'b0;

	function automatic logic signed [W_W-1:0] clip32(logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[W_W-1:0];
	endfunction

	// sigmoid lookup, built the same way as the block's ROM
	task automatic fill_sig_lut();
		logic [63:0] t, d, q;
		t = 64'd1 << 32;
		for (int k = 0; k <= 512; k++) begin
			d = (64'd1 << 32) + t;
			if (k < 512) begin
				q = ((64'd1 << 48) + (d >> 1)) / d;
				sig_lut[512 + k] = q[PROB_W-1:0];
			end
			if (k > 0) begin
				q = ((t << 16) + (d >> 1)) / d;
				sig_lut[512 - k] = q[PROB_W-1:0];
			end
			t = (t * 64'd4228380000 + (64'd1 << 31)) >> 32;
		end
	endtask

	function automatic logic signed [W_W-1:0] rd_tab(ref logic signed [W_W-1:0] tab [int],
			input int key);
		return tab.exists(key) ? tab[key] : '0;
	endfunction

	// work out the result word of one accepted item and update the tables
	task automatic predict_sgd_step(input item_t it);
		res_t r;
		int ub, vb;
		logic signed [127:0] acc, pr, e, g;
		logic signed [W_W-1:0] uo, vo;
		int ix;
		r = '0;
		ub = int'(it.cw) * DIM;
		vb = int'(it.xw) * DIM;
		if (it.op == OP_TRAIN) begin
			acc = 0;
			for (int d = 0; d < DIM; d++) begin
				pr = 128'(rd_tab(in_tab, ub + d)) * 128'(rd_tab(out_tab, vb + d));
				acc += pr >>> 24;
			end
			r.sc = clip32(acc);
			ix = (int'(r.sc) >>> 18) + 512;
			if (ix < 0) ix = 0;
			if (ix > SIG_ENTRIES - 1) ix = SIG_ENTRIES - 1;
			r.pr = sig_lut[ix];
			e = (it.lab ? 128'sd65536 : 128'sd0) - 128'($signed({1'b0, r.pr}));
			g = (128'($signed({1'b0, lr_model})) * e) >>> 16;
			for (int d = 0; d < DIM; d++) begin
				uo = rd_tab(in_tab, ub + d);
				vo = rd_tab(out_tab, vb + d);
				in_tab[ub + d] = clip32(128'(uo) + ((g * 128'(vo)) >>> 24));
				out_tab[vb + d] = clip32(128'(vo) + ((g * 128'(uo)) >>> 24));
			end
		end else if (it.el < DIM) begin
			case (op_t'(it.op))
				OP_WR_IN: in_tab[ub + it.el] = it.wv;
				OP_WR_OUT: out_tab[vb + it.el] = it.wv;
				default: begin
					r.iw = rd_tab(in_tab, ub + it.el);
					r.ow = rd_tab(out_tab, vb + it.el);
				end
			endcase
		end
		expected_results = {expected_results, r};
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// note accepted input words for the driver
	always @(posedge clk) begin
		in_fire_q <= arst_n && in_valid && in_ready;
	end

	// drive the input channel at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire_q) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
					opcode <= pending_words[0].op;
					center_word <= pending_words[0].cw;
					context_word <= pending_words[0].xw;
					label <= pending_words[0].lab;
					element_index <= pending_words[0].el;
					weight_value <= pending_words[0].wv;
					void'(pending_words.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid && pending_words.size() > 0
					&& $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				opcode <= pending_words[0].op;
				center_word <= pending_words[0].cw;
				context_word <= pending_words[0].xw;
				label <= pending_words[0].lab;
				element_index <= pending_words[0].el;
				weight_value <= pending_words[0].wv;
				void'(pending_words.pop_front());
			end
		end
	end

	// receiver: one long hold-off counted here in the stalling phase, else random stalls
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (arst_n && phase_no == 2 && !long_done) begin
			hold_off <= 400;
			long_done <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	// predict on accepted input words
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_sgd_step('{opcode, center_word, context_word, label,
				element_index, weight_value});
	end

	// check accepted result words against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected result word");
			end else begin
				want = expected_results.pop_front();
				n_checked++;
				if (want != {score, probability, in_weight, out_weight}) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: exp sc=%0d p=%0d iw=%0d ow=%0d got sc=%0d p=%0d iw=%0d ow=%0d",
							want.sc, want.pr, want.iw, want.ow,
							score, probability, in_weight, out_weight);
				end
			end
		end
	end

	function automatic item_t mk(logic [1:0] op, int cw, int xw, int lab, int el,
			logic signed [W_W-1:0] wv);
		item_t it;
		it.op = op;
		it.cw = cw[WORD_IN_W-1:0];
		it.xw = xw[WORD_IN_W-1:0];
		it.lab = lab[0];
		it.el = el[ELEM_IN_W-1:0];
		it.wv = wv;
		return it;
	endfunction

	// append one item to the pending list
	task automatic queue_word(input item_t it);
		pending_words = {pending_words, it};
	endtask

	function automatic logic signed [W_W-1:0] rnd_weight(int big);
		logic signed [W_W-1:0] w;
		w = $urandom;
		if (!big) w = w >>> $urandom_range(31, 6);
		return w;
	endfunction

	// random row index: one of the few initialised rows
	function automatic int pick_row();
		int base [NROWS] = '{0, 1, 4095, 2730};
		return base[$urandom_range(NROWS - 1)];
	endfunction

	task automatic fill_row_pair(int cw, int xw, int big);
		for (int d = 0; d < DIM; d++) begin
			queue_word(mk(OP_WR_IN, cw, 0, $urandom, d, rnd_weight(big)));
			queue_word(mk(OP_WR_OUT, 0, xw, $urandom, d, rnd_weight(big)));
		end
	endtask

	task automatic wait_drain();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_rate(logic [LR_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		lr_model = v;
	endtask

	task automatic random_phase(int n);
		int r, cw, xw;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			cw = pick_row();
			xw = pick_row();
			if (r < 45) begin
				queue_word(mk(OP_TRAIN, cw, xw, $urandom, $urandom, $urandom));
				n_train++;
			end else if (r < 65) begin
				queue_word(mk(OP_WR_IN, cw, xw, $urandom,
					$urandom_range(63), rnd_weight($urandom_range(3) == 0)));
			end else if (r < 85) begin
				queue_word(mk(OP_WR_OUT, cw, xw, $urandom,
					$urandom_range(63), rnd_weight($urandom_range(3) == 0)));
			end else begin
				queue_word(mk(OP_READ, cw, xw, $urandom,
					$urandom_range(63), $urandom));
			end
		end
	endtask

	initial begin
		int rows [NROWS] = '{0, 1, 4095, 2730};
		fill_sig_lut();
		lr_model = LR_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// initialise every row used later, so no read sees unwritten data
		for (int i = 0; i < NROWS; i++) fill_row_pair(rows[i], rows[i], 0);
		// directed: extremes, out-of-range element, reads, both labels
		queue_word(mk(OP_WR_IN, 4095, 0, 0, 0, 32'sh7fffffff));
		queue_word(mk(OP_WR_OUT, 0, 4095, 0, 0, 32'sh7fffffff));
		queue_word(mk(OP_WR_IN, 0, 0, 1, 49, 32'sh80000000));
		queue_word(mk(OP_WR_OUT, 0, 0, 1, 49, 32'sh80000000));
		queue_word(mk(OP_WR_IN, 1, 1, 1, 50, 32'sh12345678));
		queue_word(mk(OP_WR_OUT, 1, 1, 0, 63, 32'shffffffff));
		queue_word(mk(OP_READ, 4095, 4095, 0, 0, 0));
		queue_word(mk(OP_READ, 0, 0, 1, 49, 32'shffffffff));
		queue_word(mk(OP_READ, 1, 1, 0, 63, 0));
		queue_word(mk(OP_READ, 1, 1, 0, 50, 0));
		queue_word(mk(OP_TRAIN, 4095, 4095, 1, 0, 0));
		queue_word(mk(OP_TRAIN, 4095, 0, 0, 63, 32'shffffffff));
		queue_word(mk(OP_TRAIN, 0, 0, 1, 0, 0));
		queue_word(mk(OP_TRAIN, 1, 1, 0, 0, 0));
		queue_word(mk(OP_READ, 4095, 4095, 0, 0, 0));
		n_train += 4;
		wait_drain();

		// phases: idling mix times learning-rate setting
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_rate(24'd0);
				1: set_rate(24'hffffff);
				2: set_rate(24'd83886);
				3: set_rate(LR_W'($urandom));
				default: set_rate(24'h100000);
			endcase
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 57; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 57; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			if (ph == 3) begin
				// refresh rows with large values to reach saturation
				for (int i = 0; i < 2; i++) fill_row_pair(rows[i], rows[i], 1);
			end
			phase_no = ph;
			random_phase(130);
			wait_drain();
		end

		$display("checked %0d result words, %0d of them train steps, over five rates",
			n_checked, n_train);
		if (n_mismatch == 0)
			$display("skipgram_negative_sampling_update_top_tb OK");
		else
			$display("skipgram_negative_sampling_update_top_tb NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("skipgram_negative_sampling_update_top_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
